// ----- rtl/core/fcfs_pkg.sv -----
// ----------------------------------------------------------------------------
// fcfs_pkg
// Shared sizes, codes and controller/datapath interface types for the
// chained-block file store.
// ----------------------------------------------------------------------------
package fcfs_pkg;

    localparam int BLOCK_COUNT     = 1024;
    localparam int BYTES_PER_BLOCK = 32;
    localparam int DIR_SLOTS       = 128;

    localparam int KEY_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int OFF_W   = 15;
    localparam int SIZE_W  = 16;
    localparam int STAT_W  = 3;
    localparam int BLK_W   = $clog2(BLOCK_COUNT);
    localparam int LINK_W  = BLK_W + 1;
    localparam int CNT_W   = BLK_W + 1;
    localparam int SLOT_W  = $clog2(DIR_SLOTS);
    localparam int POS_W   = $clog2(BYTES_PER_BLOCK);
    localparam int BADDR_W = BLK_W + POS_W;
    localparam int STORE_DEPTH = BLOCK_COUNT * BYTES_PER_BLOCK;

    localparam logic [LINK_W-1:0] END_MARK = {LINK_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_READ   = 2'd2,
        CMD_DELETE = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADNAME  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  name;
        logic [BLK_W-1:0]  first;
        logic [SIZE_W-1:0] size;
    } t_dir_ent;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_DSCAN, S_DECIDE, S_FSCAN, S_FCHK,
        S_MARK, S_WALK, S_WWAIT, S_AFTER_WALK, S_BWRITE, S_BREAD,
        S_DEL, S_DWAIT, S_DIRCLR, S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    clr;
        logic    dscan_start;
        logic    dscan_step;
        logic    fscan_start;
        logic    fscan_step;
        logic    walk_init_app;
        logic    walk_init_rd;
        logic    walk_take;
        logic    del_init;
        logic    del_take;
        logic    link_last;
        logic    mark_j;
        logic    dir_create;
        logic    dir_append;
        logic    dir_clear;
        logic    byte_write;
        logic    byte_take;
        logic    set_st;
        t_status st;
        logic    size_cur;
        logic    size_inc;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic sweep_done;
        logic dscan_done;
        logic fscan_done;
        logic found;
        logic eok;
        logic fok;
        logic key_zero;
        logic size_max;
        logic need_blk;
        logic off_range;
        logic walk_more;
        logic walk_stop;
        logic del_more;
        logic del_end;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/core/fcfs_dp.sv -----
// ----------------------------------------------------------------------------
// fcfs_dp
// Datapath: block table, directory and byte store memories, scan counters,
// chain pointer, request latch and result register.
// ----------------------------------------------------------------------------
module fcfs_dp import fcfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [1:0]         i_command,
    input  logic [KEY_W-1:0]   i_name_key,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic [OFF_W-1:0]   i_byte_offset,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [BYTE_W-1:0]  o_read_byte,
    output logic [SIZE_W-1:0]  o_file_size
);

    logic [LINK_W-1:0] tbl_mem [BLOCK_COUNT];
    t_dir_ent          dir_mem [DIR_SLOTS];
    logic [BYTE_W-1:0] byte_mem [STORE_DEPTH];

    t_cmd              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [BYTE_W-1:0] r_data;
    logic [OFF_W-1:0]  r_off;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pv;
    logic [BLK_W-1:0]  r_pidx;
    logic              r_found, r_eok, r_fok;
    logic [SLOT_W-1:0] r_slot, r_eslot;
    logic [BLK_W-1:0]  r_first;
    logic [SIZE_W-1:0] r_size;
    logic [LINK_W-1:0] r_b;
    logic [CNT_W-1:0]  r_steps, r_hops;
    logic [BLK_W-1:0]  r_j;
    t_status           r_st;
    logic [BYTE_W-1:0] r_rbyte;
    logic [SIZE_W-1:0] r_rsize;
    logic [LINK_W-1:0] r_tbl_q;
    t_dir_ent          r_dir_q;
    logic [BYTE_W-1:0] r_byte_q;
    logic              r_ovalid;
    t_status           r_o_st;
    logic [BYTE_W-1:0] r_o_byte;
    logic [SIZE_W-1:0] r_o_size;

    logic [BLK_W-1:0]   tbl_a;
    logic               tbl_we;
    logic [LINK_W-1:0]  tbl_wd;
    logic [SLOT_W-1:0]  dir_a;
    logic               dir_we;
    t_dir_ent           dir_wd;
    logic [BADDR_W-1:0] byte_a;
    logic               tbl_stop;

    // Select block table port
    always_comb begin
        tbl_a  = r_b[BLK_W-1:0];
        tbl_we = 1'b0;
        tbl_wd = '0;
        if (i_cmd.clr) begin
            tbl_a  = r_cnt[BLK_W-1:0];
            tbl_we = 1'b1;
        end else if (i_cmd.fscan_start || i_cmd.fscan_step) begin
            tbl_a = r_cnt[BLK_W-1:0];
        end else if (i_cmd.del_take) begin
            tbl_we = 1'b1;
        end else if (i_cmd.link_last) begin
            tbl_we = 1'b1;
            tbl_wd = {1'b0, r_j};
        end else if (i_cmd.mark_j) begin
            tbl_a  = r_j;
            tbl_we = 1'b1;
            tbl_wd = END_MARK;
        end
    end

    // Select directory port
    always_comb begin
        dir_a  = r_cnt[SLOT_W-1:0];
        dir_we = 1'b0;
        dir_wd = '0;
        if (i_cmd.clr) begin
            dir_we = (r_cnt < CNT_W'(DIR_SLOTS));
        end else if (i_cmd.dir_create) begin
            dir_a  = r_eslot;
            dir_we = 1'b1;
            dir_wd = '{name: r_key, first: r_j, size: '0};
        end else if (i_cmd.dir_append) begin
            dir_a  = r_slot;
            dir_we = 1'b1;
            dir_wd = '{name: r_key, first: r_first, size: SIZE_W'(r_size + 1'b1)};
        end else if (i_cmd.dir_clear) begin
            dir_a  = r_slot;
            dir_we = 1'b1;
        end
    end

    // Select byte store address: write at the file end, read at the offset
    always_comb begin
        if (i_cmd.byte_write) begin
            byte_a = {r_b[BLK_W-1:0], r_size[POS_W-1:0]};
        end else begin
            byte_a = {r_b[BLK_W-1:0], r_off[POS_W-1:0]};
        end
    end

    // Memories with registered read data
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_a] <= tbl_wd;
        end
        r_tbl_q <= tbl_mem[tbl_a];
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_a] <= dir_wd;
        end
        r_dir_q <= dir_mem[dir_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_write) begin
            byte_mem[byte_a] <= r_data;
        end
        r_byte_q <= byte_mem[byte_a];
    end

    assign tbl_stop = (r_tbl_q == END_MARK) || (r_tbl_q == '0)
                   || (r_tbl_q >= LINK_W'(BLOCK_COUNT));

    // Control registers: sweep counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr || i_cmd.dscan_step || i_cmd.fscan_step) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.dscan_start) begin
                r_cnt <= '0;
            end else if (i_cmd.fscan_start) begin
                r_cnt <= CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request latch, scan results, chain pointer and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= t_cmd'(i_command);
            r_key   <= i_name_key;
            r_data  <= i_data_byte;
            r_off   <= i_byte_offset;
            r_st    <= ST_OK;
            r_rbyte <= '0;
            r_rsize <= '0;
        end
        // pipelined directory scan
        if (i_cmd.dscan_start) begin
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_eok   <= 1'b0;
        end
        if (i_cmd.dscan_step) begin
            r_pv   <= 1'b1;
            r_pidx <= r_cnt[BLK_W-1:0];
            if (r_pv && r_dir_q.name == r_key && !r_found) begin
                r_found <= 1'b1;
                r_slot  <= r_pidx[SLOT_W-1:0];
                r_first <= r_dir_q.first;
                r_size  <= r_dir_q.size;
            end
            if (r_pv && r_dir_q.name == '0 && !r_eok) begin
                r_eok   <= 1'b1;
                r_eslot <= r_pidx[SLOT_W-1:0];
            end
        end
        // pipelined free-block scan
        if (i_cmd.fscan_start) begin
            r_pv  <= 1'b0;
            r_fok <= 1'b0;
        end
        if (i_cmd.fscan_step) begin
            r_pv   <= 1'b1;
            r_pidx <= r_cnt[BLK_W-1:0];
            if (r_pv && r_tbl_q == '0 && !r_fok) begin
                r_fok <= 1'b1;
                r_j   <= r_pidx;
            end
        end
        // chain walk and delete
        if (i_cmd.walk_init_app || i_cmd.walk_init_rd || i_cmd.del_init) begin
            r_b     <= {1'b0, r_first};
            r_steps <= '0;
        end
        if (i_cmd.walk_init_app) begin
            r_hops <= CNT_W'(BLOCK_COUNT);
        end
        if (i_cmd.walk_init_rd) begin
            r_hops <= CNT_W'(r_off >> POS_W);
        end
        if ((i_cmd.walk_take && !tbl_stop) || (i_cmd.del_take && r_tbl_q != END_MARK)) begin
            r_b     <= r_tbl_q;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.mark_j) begin
            r_b <= {1'b0, r_j};
        end
        // result fields
        if (i_cmd.set_st) begin
            r_st <= i_cmd.st;
        end
        if (i_cmd.size_cur) begin
            r_rsize <= r_size;
        end
        if (i_cmd.size_inc) begin
            r_rsize <= SIZE_W'(r_size + 1'b1);
        end
        if (i_cmd.byte_take) begin
            r_rbyte <= r_byte_q;
        end
        if (i_cmd.out_load) begin
            r_o_st   <= r_st;
            r_o_byte <= r_rbyte;
            r_o_size <= r_rsize;
        end
    end

    // Status back to the controller
    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.sweep_done = (r_cnt == CNT_W'(BLOCK_COUNT - 1));
        o_stat.dscan_done = r_pv && (r_pidx == BLK_W'(DIR_SLOTS - 1));
        o_stat.fscan_done = r_pv && ((r_tbl_q == '0) || (r_pidx == BLK_W'(BLOCK_COUNT - 1)));
        o_stat.found      = r_found;
        o_stat.eok        = r_eok;
        o_stat.fok        = r_fok;
        o_stat.key_zero   = (r_key == '0);
        o_stat.size_max   = (r_size == SIZE_MAX);
        o_stat.need_blk   = (r_size != '0) && (r_size[POS_W-1:0] == '0);
        o_stat.off_range  = (SIZE_W'(r_off) >= r_size);
        o_stat.walk_more  = (r_steps < r_hops);
        o_stat.walk_stop  = tbl_stop;
        o_stat.del_more   = (r_steps < CNT_W'(BLOCK_COUNT)) && (r_b != '0)
                         && (r_b < LINK_W'(BLOCK_COUNT));
        o_stat.del_end    = (r_tbl_q == END_MARK);
        o_stat.out_free   = !r_ovalid || i_ready;
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_o_st;
    assign o_read_byte = r_o_byte;
    assign o_file_size = r_o_size;

endmodule

// ----- rtl/core/fcfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcfs_ctrl
// Controller: sequences the clearing sweep and each request through
// directory scan, free-block scan, chain walk and memory updates.
// ----------------------------------------------------------------------------
module fcfs_ctrl import fcfs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.st = ST_OK;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.key_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_BADNAME;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.dscan_start = 1'b1;
                    n_state           = S_DSCAN;
                end
            end
            S_DSCAN: begin
                o_cmd.dscan_step = 1'b1;
                if (i_stat.dscan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (i_stat.cmd == CMD_CREATE) begin
                    if (i_stat.found) begin
                        o_cmd.set_st   = 1'b1;
                        o_cmd.st       = ST_BADNAME;
                        o_cmd.size_cur = 1'b1;
                    end else if (!i_stat.eok) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_FULL;
                    end else begin
                        o_cmd.fscan_start = 1'b1;
                        n_state           = S_FSCAN;
                    end
                end else if (!i_stat.found) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_NOTFOUND;
                end else begin
                    unique case (i_stat.cmd)
                        CMD_APPEND: begin
                            if (i_stat.size_max) begin
                                o_cmd.set_st   = 1'b1;
                                o_cmd.st       = ST_FULL;
                                o_cmd.size_cur = 1'b1;
                            end else begin
                                o_cmd.walk_init_app = 1'b1;
                                n_state             = S_WALK;
                            end
                        end
                        CMD_READ: begin
                            if (i_stat.off_range) begin
                                o_cmd.set_st   = 1'b1;
                                o_cmd.st       = ST_RANGE;
                                o_cmd.size_cur = 1'b1;
                            end else begin
                                o_cmd.walk_init_rd = 1'b1;
                                n_state            = S_WALK;
                            end
                        end
                        CMD_DELETE: begin
                            o_cmd.del_init = 1'b1;
                            n_state        = S_DEL;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FSCAN: begin
                o_cmd.fscan_step = 1'b1;
                if (i_stat.fscan_done) n_state = S_FCHK;
            end
            S_FCHK: begin
                n_state = S_DONE;
                if (!i_stat.fok) begin
                    o_cmd.set_st   = 1'b1;
                    o_cmd.st       = ST_FULL;
                    o_cmd.size_cur = (i_stat.cmd == CMD_APPEND);
                end else if (i_stat.cmd == CMD_CREATE) begin
                    o_cmd.mark_j     = 1'b1;
                    o_cmd.dir_create = 1'b1;
                end else begin
                    o_cmd.link_last = 1'b1;
                    n_state         = S_MARK;
                end
            end
            S_MARK: begin
                o_cmd.mark_j = 1'b1;
                n_state      = S_BWRITE;
            end
            S_WALK: begin
                if (i_stat.walk_more) n_state = S_WWAIT;
                else                  n_state = S_AFTER_WALK;
            end
            S_WWAIT: begin
                o_cmd.walk_take = 1'b1;
                if (i_stat.walk_stop) n_state = S_AFTER_WALK;
                else                  n_state = S_WALK;
            end
            S_AFTER_WALK: begin
                if (i_stat.cmd == CMD_READ) begin
                    n_state = S_BREAD;
                end else if (i_stat.need_blk) begin
                    o_cmd.fscan_start = 1'b1;
                    n_state           = S_FSCAN;
                end else begin
                    n_state = S_BWRITE;
                end
            end
            S_BWRITE: begin
                o_cmd.byte_write = 1'b1;
                o_cmd.dir_append = 1'b1;
                o_cmd.size_inc   = 1'b1;
                n_state          = S_DONE;
            end
            S_BREAD: begin
                o_cmd.byte_take = 1'b1;
                o_cmd.size_cur  = 1'b1;
                n_state         = S_DONE;
            end
            S_DEL: begin
                if (i_stat.del_more) n_state = S_DWAIT;
                else                 n_state = S_DIRCLR;
            end
            S_DWAIT: begin
                o_cmd.del_take = 1'b1;
                if (i_stat.del_end) n_state = S_DIRCLR;
                else                n_state = S_DEL;
            end
            S_DIRCLR: begin
                o_cmd.dir_clear = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/fat_chain_file_store_core.sv -----
// Each request goes through the directory scan, plus a free-block scan on create or
// on an append that opens a block, plus a chain walk on append, read and delete;
// one request at a time. A finished result waits in the output register while the
// next request is taken.
// Reset: a clearing sweep empties the block table and directory; no request is
// accepted until it finishes.
// ----------------------------------------------------------------------------
// fat_chain_file_store_core
// Chained-block file store: create, append byte, read byte and delete on
// named files, with a block allocation table, directory and byte store.
// ----------------------------------------------------------------------------
module fat_chain_file_store_core import fcfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [KEY_W-1:0]   i_name_key,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic [OFF_W-1:0]   i_byte_offset,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [BYTE_W-1:0]  o_read_byte,
    output logic [SIZE_W-1:0]  o_file_size
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence each request
    fcfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Hold memories and working registers
    fcfs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_command),
        .i_name_key    (i_name_key),
        .i_data_byte   (i_data_byte),
        .i_byte_offset (i_byte_offset),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_read_byte   (o_read_byte),
        .o_file_size   (o_file_size)
    );

endmodule

// ----- bench/fat_chain_file_store_checker.sv -----
// ----------------------------------------------------------------------------
// fat_chain_file_store_checker
// Watches both channels of the file store, keeps its own copy of the block
// table, directory and byte store, predicts one response per request and
// compares it field by field in order.
// ----------------------------------------------------------------------------
module fat_chain_file_store_checker import fcfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [1:0]         i_command,
    input  logic [KEY_W-1:0]   i_name_key,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic [OFF_W-1:0]   i_byte_offset,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic [STAT_W-1:0]  i_status,
    input  logic [BYTE_W-1:0]  i_read_byte,
    input  logic [SIZE_W-1:0]  i_file_size,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status           st;
        logic [BYTE_W-1:0] rbyte;
        logic [SIZE_W-1:0] fsize;
    } t_rsp;

    logic [LINK_W-1:0] link_tbl [BLOCK_COUNT];
    logic [KEY_W-1:0]  dir_key  [DIR_SLOTS];
    logic [BLK_W-1:0]  dir_head [DIR_SLOTS];
    logic [SIZE_W-1:0] dir_len  [DIR_SLOTS];
    logic [BYTE_W-1:0] data_mem [STORE_DEPTH];

    t_rsp rsp_q[$];
    int   n_req;
    int   n_rsp;

    assign o_pending = n_req - n_rsp;

    function automatic int slot_of(logic [KEY_W-1:0] key);
        for (int i = 0; i < DIR_SLOTS; i++)
            if (dir_key[i] == key) return i;
        return -1;
    endfunction

    function automatic int first_free_block();
        for (int j = 1; j < BLOCK_COUNT; j++)
            if (link_tbl[j] == '0) return j;
        return -1;
    endfunction

    // Follow up to hops links, stopping at the end mark or a bad link
    function automatic int follow_chain(int start, int hops);
        int b;
        int nb;
        b = start;
        for (int i = 0; i < hops && i < BLOCK_COUNT; i++) begin
            nb = link_tbl[b];
            if (nb == END_MARK || nb == 0 || nb >= BLOCK_COUNT) break;
            b = nb;
        end
        return b;
    endfunction

    // Apply one request to the shadow store and return its response
    function automatic t_rsp apply_request(t_cmd cmd, logic [KEY_W-1:0] key,
                                           logic [BYTE_W-1:0] data,
                                           logic [OFF_W-1:0] off);
        t_rsp r;
        int s;
        int j;
        int sz;
        int last;
        int pos;
        int b;
        int nb;
        r = '{st: ST_OK, rbyte: '0, fsize: '0};
        if (key == '0) begin
            r.st = ST_BADNAME;
        end else if (cmd == CMD_CREATE) begin
            s = slot_of(key);
            if (s >= 0) begin
                r.st    = ST_BADNAME;
                r.fsize = dir_len[s];
            end else begin
                s = slot_of('0);
                j = first_free_block();
                if (s < 0 || j < 0) begin
                    r.st = ST_FULL;
                end else begin
                    link_tbl[j] = END_MARK;
                    dir_key[s]  = key;
                    dir_head[s] = BLK_W'(j);
                    dir_len[s]  = '0;
                end
            end
        end else begin
            s = slot_of(key);
            if (s < 0) begin
                r.st = ST_NOTFOUND;
            end else if (cmd == CMD_APPEND) begin
                sz   = dir_len[s];
                last = follow_chain(dir_head[s], BLOCK_COUNT);
                pos  = sz % BYTES_PER_BLOCK;
                if (sz >= SIZE_MAX) begin
                    r.st = ST_FULL;
                end else if (sz > 0 && pos == 0) begin
                    j = first_free_block();
                    if (j < 0) begin
                        r.st = ST_FULL;
                    end else begin
                        link_tbl[last] = LINK_W'(j);
                        link_tbl[j]    = END_MARK;
                        last           = j;
                    end
                end
                if (r.st == ST_OK) begin
                    data_mem[last * BYTES_PER_BLOCK + pos] = data;
                    dir_len[s] = SIZE_W'(sz + 1);
                end
                r.fsize = dir_len[s];
            end else if (cmd == CMD_READ) begin
                r.fsize = dir_len[s];
                if (off >= dir_len[s]) begin
                    r.st = ST_RANGE;
                end else begin
                    b = follow_chain(dir_head[s], off / BYTES_PER_BLOCK);
                    r.rbyte = data_mem[b * BYTES_PER_BLOCK + off % BYTES_PER_BLOCK];
                end
            end else begin
                b = dir_head[s];
                for (int n = 0; n < BLOCK_COUNT && b != 0 && b < BLOCK_COUNT; n++) begin
                    nb = link_tbl[b];
                    link_tbl[b] = '0;
                    if (nb == END_MARK) break;
                    b = nb;
                end
                dir_key[s]  = '0;
                dir_head[s] = '0;
                dir_len[s]  = '0;
            end
        end
        return r;
    endfunction

    initial begin
        o_errors = 0;
        n_req    = 0;
        n_rsp    = 0;
        foreach (link_tbl[i]) link_tbl[i] = '0;
        foreach (dir_key[i]) begin
            dir_key[i]  = '0;
            dir_head[i] = '0;
            dir_len[i]  = '0;
        end
        foreach (data_mem[i]) data_mem[i] = '0;
    end

    // Predict on each accepted request, compare each accepted response
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                rsp_q.push_back(apply_request(t_cmd'(i_command), i_name_key,
                                              i_data_byte, i_byte_offset));
                n_req++;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_q.size() == 0) begin
                    $error("response with no request outstanding");
                    o_errors++;
                end else begin
                    want = rsp_q.pop_front();
                    n_rsp++;
                    if (i_status !== want.st) begin
                        $error("status: expected %0d got %0d", want.st, i_status);
                        o_errors++;
                    end
                    if (i_read_byte !== want.rbyte) begin
                        $error("read_byte: expected %0d got %0d", want.rbyte, i_read_byte);
                        o_errors++;
                    end
                    if (i_file_size !== want.fsize) begin
                        $error("file_size: expected %0d got %0d", want.fsize, i_file_size);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/fat_chain_file_store_core_tb.sv -----
// ----------------------------------------------------------------------------
// fat_chain_file_store_core_tb
// Drives directed and random file requests with random gaps and response
// stalls into the file store; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module fat_chain_file_store_core_tb;
    import fcfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_command;
    logic [KEY_W-1:0]   i_name_key;
    logic [BYTE_W-1:0]  i_data_byte;
    logic [OFF_W-1:0]   i_byte_offset;
    logic               o_valid;
    logic               i_ready;
    logic [STAT_W-1:0]  o_status;
    logic [BYTE_W-1:0]  o_read_byte;
    logic [SIZE_W-1:0]  o_file_size;

    int errors;
    int pending;
    int n_sent;
    logic hold_off_req;
    logic [KEY_W-1:0] key_pool [16];

    fat_chain_file_store_core u_dut (.*);

    fat_chain_file_store_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_command     (i_command),
        .i_name_key    (i_name_key),
        .i_data_byte   (i_data_byte),
        .i_byte_offset (i_byte_offset),
        .i_rsp_valid   (o_valid),
        .i_rsp_ready   (i_ready),
        .i_status      (o_status),
        .i_read_byte   (o_read_byte),
        .i_file_size   (o_file_size),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one request, hold it until accepted, then idle for a random gap
    task automatic send_request(t_cmd cmd, logic [KEY_W-1:0] key,
                                logic [BYTE_W-1:0] data, logic [OFF_W-1:0] off);
        int r;
        int gap;
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_name_key    <= key;
        i_data_byte   <= data;
        i_byte_offset <= off;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
        r   = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(20, 80);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Pick a random request, biased toward a few hot files
    task automatic send_random();
        int r;
        int k;
        t_cmd cmd;
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] off;
        r   = $urandom_range(0, 99);
        cmd = t_cmd'($urandom_range(0, 3));
        if (r < 4) begin
            key = '0;
        end else if (r < 8) begin
            key = {$urandom, $urandom};
        end else begin
            k   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            key = key_pool[k];
            r   = $urandom_range(0, 99);
            cmd = (r < 45) ? CMD_APPEND : (r < 72) ? CMD_READ :
                  (r < 90) ? CMD_CREATE : CMD_DELETE;
        end
        off = ($urandom_range(0, 9) < 8) ? OFF_W'($urandom_range(0, 300))
                                         : OFF_W'($urandom_range(0, 32767));
        send_request(cmd, key, BYTE_W'($urandom_range(0, 255)), off);
    endtask

    // Response side: random ready with one long hold-off on request
    initial begin
        int gap;
        int r;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                r   = $urandom_range(0, 99);
                gap = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(30, 120);
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [KEY_W-1:0] k1;
        n_sent        = 0;
        hold_off_req  = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= CMD_CREATE;
        i_name_key    <= '0;
        i_data_byte   <= '0;
        i_byte_offset <= '0;
        foreach (key_pool[i]) begin
            key_pool[i] = {$urandom, $urandom};
            if (key_pool[i] == '0) key_pool[i] = 64'd1;
        end
        key_pool[15] = '1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: invalid name, duplicates, unknown names, range edges
        k1 = key_pool[0];
        send_request(CMD_CREATE, '0, 8'h00, '0);
        send_request(CMD_APPEND, '0, 8'hFF, '0);
        send_request(CMD_READ,   '0, 8'h00, '1);
        send_request(CMD_DELETE, '0, 8'h00, '0);
        send_request(CMD_APPEND, k1, 8'h5A, '0);
        send_request(CMD_READ,   k1, 8'h00, '0);
        send_request(CMD_DELETE, k1, 8'h00, '0);
        send_request(CMD_CREATE, k1, 8'h00, '0);
        send_request(CMD_CREATE, k1, 8'h00, '0);
        send_request(CMD_READ,   k1, 8'h00, '0);
        send_request(CMD_APPEND, k1, 8'h00, '0);
        send_request(CMD_APPEND, k1, 8'hFF, '0);
        send_request(CMD_APPEND, k1, 8'hA5, '0);
        send_request(CMD_CREATE, k1, 8'h00, '0);
        send_request(CMD_READ,   k1, 8'h00, 15'd0);
        send_request(CMD_READ,   k1, 8'h00, 15'd2);
        send_request(CMD_READ,   k1, 8'h00, 15'd3);
        send_request(CMD_READ,   k1, 8'h00, '1);
        send_request(CMD_CREATE, '1, 8'h00, '0);
        send_request(CMD_APPEND, '1, 8'h3C, '0);
        send_request(CMD_DELETE, '1, 8'h00, '0);
        send_request(CMD_DELETE, k1, 8'h00, '0);
        send_request(CMD_READ,   k1, 8'h00, '0);

        // Fill the directory past its last slot, then empty it
        for (int i = 1; i <= 130; i++)
            send_request(CMD_CREATE, {32'hD1A0_0000, 32'(i)},
                         BYTE_W'($urandom_range(0, 255)), '0);
        for (int i = 1; i <= 130; i++)
            send_request(CMD_DELETE, {32'hD1A0_0000, 32'(i)}, 8'h00, '0);

        // Random traffic; one long response stall along the way
        for (int i = 0; i < 870; i++) begin
            if (i == 300) hold_off_req = 1'b1;
            send_random();
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
